@@ src/pbws_pkg.sv @@
// Package for the band-limited waveform shaper: widths, command codes,
// pipeline side-band types and the residual setup function.
// No dependencies.
package pbws_pkg;

  localparam int PHASE_BITS      = 16;
  localparam int SAMPLE_BITS     = 16;
  localparam int FRAC_BITS       = SAMPLE_BITS - 1;
  localparam int INC_BITS        = PHASE_BITS - 1;
  localparam int Q_BITS          = FRAC_BITS + 1;
  localparam int REM_BITS        = INC_BITS + 1;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (Q_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int SQ_BITS         = 2 * Q_BITS;
  localparam int SUM_BITS        = SAMPLE_BITS + 2;
  localparam int SAW_UP          = FRAC_BITS + 1 - PHASE_BITS;
  localparam int SAW_SHL         = (SAW_UP > 0) ? SAW_UP : 0;
  localparam int SAW_SHR         = (SAW_UP < 0) ? -SAW_UP : 0;

  localparam logic [PHASE_BITS:0] CYCLE = {1'b1, {PHASE_BITS{1'b0}}};

  typedef enum logic {
    CMD_SAW    = 1'b0,
    CMD_SQUARE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                  act;
    logic                  start;
    logic [INC_BITS-1:0]   n;
  } blep_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] base;
    logic                        act0;
    logic                        neg0;
    logic                        act1;
    logic                        neg1;
  } side_t;

  function automatic blep_req_t blep_prep(input logic [PHASE_BITS-1:0] x,
                                          input logic [INC_BITS-1:0]   d);
    logic [PHASE_BITS:0] sum;
    blep_req_t           r;
    sum     = {1'b0, x} + (PHASE_BITS + 1)'(d);
    r.act   = 1'b0;
    r.start = 1'b0;
    r.n     = '0;
    if (d != '0) begin
      if (x < PHASE_BITS'(d)) begin
        r.act   = 1'b1;
        r.start = 1'b1;
        r.n     = INC_BITS'(PHASE_BITS'(d) - x);
      end else if (sum > CYCLE) begin
        r.act   = 1'b1;
        r.start = 1'b0;
        r.n     = sum[INC_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ src/pbws_ifs.sv @@
// Channel interfaces of the waveform shaper: request in, sample out.
// Depends on pbws_pkg.
interface pbws_in_if;
  import pbws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [PHASE_BITS-1:0] phase;
  logic [INC_BITS-1:0]   increment;

  modport source (output valid, output command, output phase, output increment,
                  input ready);
  modport sink   (input valid, input command, input phase, input increment,
                  output ready);
endinterface

interface pbws_out_if;
  import pbws_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ src/pbws_div.sv @@
// Pipelined restoring divider: quotient of (num << FRAC_BITS) / den for num <= den.
// Two quotient bits per stage; each stage loads on its own enable bit.
// Depends on pbws_pkg.
module pbws_div (
  input  logic                               clk,
  input  logic [pbws_pkg::DIV_STAGES-1:0]    en,
  input  logic [pbws_pkg::INC_BITS-1:0]      num_i,
  input  logic [pbws_pkg::INC_BITS-1:0]      den_i,
  output logic [pbws_pkg::Q_BITS-1:0]        quo_o
);
  import pbws_pkg::*;

  logic [REM_BITS-1:0] rem_r [DIV_STAGES];
  logic [INC_BITS-1:0] den_r [DIV_STAGES];
  logic [Q_BITS-1:0]   quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    logic [REM_BITS-1:0] r_in;
    logic [REM_BITS-1:0] r_nxt;
    logic [REM_BITS-1:0] t;
    logic [INC_BITS-1:0] d_in;
    logic [Q_BITS-1:0]   q_in;
    logic [Q_BITS-1:0]   q_nxt;

    if (s == 0) begin : g_first
      assign r_in = REM_BITS'(num_i);
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[s-1];
      assign d_in = den_r[s-1];
      assign q_in = quo_r[s-1];
    end

    always_comb begin
      r_nxt = r_in;
      q_nxt = q_in;
      t     = '0;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < Q_BITS) begin
          if (s * STEPS_PER_STAGE + j == 0) begin
            t = r_nxt;
          end else begin
            t = r_nxt << 1;
          end
          if (t >= REM_BITS'(d_in)) begin
            r_nxt = t - REM_BITS'(d_in);
            q_nxt = {q_nxt[Q_BITS-2:0], 1'b1};
          end else begin
            r_nxt = t;
            q_nxt = {q_nxt[Q_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= r_nxt;
        den_r[s] <= d_in;
        quo_r[s] <= q_nxt;
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

@@ src/polyblep_waveform_shaper_unit.sv @@
// Band-limited sawtooth / square sample generator, top level.
// Depends on pbws_pkg, pbws_ifs (channel interfaces) and pbws_div.
//
// Usage:
//   in_chan carries one request per handshake: command (0 saw, 1 square),
//   phase and increment as unsigned fractions of a cycle. out_chan returns
//   one signed Q1.15 sample per request, in request order.
//   A request is taken at a rising edge with valid and ready both high.
// Pipeline: setup stage, eight divider stages, squaring stage, and a
//   sum and saturate stage between request and sample valid.
// Throughput: one request per cycle while out_chan.ready is high; the
//   pipelined divider, two quotient bits per stage, sets this figure.
// Reset: rst_n low clears all stage valid bits; in-flight requests are
//   dropped and no sample is shown until new requests arrive.
// Stall: when out_chan.ready is low the output stage holds its sample;
//   earlier stages keep filling bubbles, and in_chan.ready drops only
//   once every stage holds a request.
module polyblep_waveform_shaper_unit (
  input  logic       clk,
  input  logic       rst_n,
  pbws_in_if.sink    in_chan,
  pbws_out_if.source out_chan
);
  import pbws_pkg::*;

  localparam int NSTG = DIV_STAGES + 3;
  localparam int MSTG = DIV_STAGES + 1;
  localparam int OSTG = DIV_STAGES + 2;
  localparam logic signed [SAMPLE_BITS:0] ONE_Q = (SAMPLE_BITS + 1)'(1) <<< FRAC_BITS;
  localparam logic [SQ_BITS-1:0]   RND    = SQ_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [SQ_BITS-1:0]   SQ_MAX = SQ_BITS'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_BITS-1:0] MAX_V = (SUM_BITS'(1) <<< FRAC_BITS) - 1;
  localparam logic signed [SUM_BITS-1:0] MIN_V = -(SUM_BITS'(1) <<< FRAC_BITS);

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  logic [INC_BITS-1:0] a_n0_r;
  logic [INC_BITS-1:0] a_n1_r;
  logic [INC_BITS-1:0] a_d_r;
  side_t               a_side_r;
  side_t               a_side_nxt;
  side_t               side_r [DIV_STAGES];
  side_t               m_side_r;
  logic [SQ_BITS-1:0]  sq0_r;
  logic [SQ_BITS-1:0]  sq1_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;

  logic [Q_BITS-1:0]   q0;
  logic [Q_BITS-1:0]   q1;

  cmd_t                          cmd;
  logic [PHASE_BITS-1:0]         p2;
  logic [PHASE_BITS+SAW_SHL-1:0] saw_wide;
  logic [SAMPLE_BITS-1:0]        saw_scaled;
  logic signed [SAMPLE_BITS-1:0] saw;
  blep_req_t                     req0;
  blep_req_t                     req1;

  logic [Q_BITS-1:0]           m0;
  logic [Q_BITS-1:0]           m1;
  logic signed [SUM_BITS-1:0]  t0;
  logic signed [SUM_BITS-1:0]  t1;
  logic signed [SUM_BITS-1:0]  sum_v;

  // ready chain: a stage loads when empty or when its successor loads
  assign rdy[NSTG] = out_chan.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        if (k == 0) begin
          v_nxt[k] = in_chan.valid;
        end else begin
          v_nxt[k] = v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_chan.ready = rdy[0];

  // setup stage
  always_comb begin
    cmd        = cmd_t'(in_chan.command);
    p2         = {~in_chan.phase[PHASE_BITS-1], in_chan.phase[PHASE_BITS-2:0]};
    saw_wide   = (PHASE_BITS + SAW_SHL)'(in_chan.phase) << SAW_SHL;
    saw_scaled = SAMPLE_BITS'(saw_wide >> SAW_SHR);
    saw        = signed'({~saw_scaled[SAMPLE_BITS-1], saw_scaled[SAMPLE_BITS-2:0]});
    req0       = blep_prep(in_chan.phase, in_chan.increment);
    req1       = blep_prep(p2, in_chan.increment);

    a_side_nxt.act0 = req0.act;
    a_side_nxt.act1 = req1.act && (cmd == CMD_SQUARE);
    a_side_nxt.neg1 = !req1.start;
    unique case (cmd)
      CMD_SAW: begin
        a_side_nxt.base = (SAMPLE_BITS + 1)'(saw);
        a_side_nxt.neg0 = !req0.start;
      end
      CMD_SQUARE: begin
        a_side_nxt.base = in_chan.phase[PHASE_BITS-1] ? -ONE_Q : ONE_Q;
        a_side_nxt.neg0 = req0.start;
      end
      default: begin
        a_side_nxt.base = '0;
        a_side_nxt.neg0 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_n0_r   <= req0.n;
      a_n1_r   <= req1.n;
      a_d_r    <= in_chan.increment;
      a_side_r <= a_side_nxt;
    end
  end

  // divider stages
  pbws_div u_div0 (
    .clk   (clk),
    .en    (rdy[DIV_STAGES:1]),
    .num_i (a_n0_r),
    .den_i (a_d_r),
    .quo_o (q0)
  );

  pbws_div u_div1 (
    .clk   (clk),
    .en    (rdy[DIV_STAGES:1]),
    .num_i (a_n1_r),
    .den_i (a_d_r),
    .quo_o (q1)
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rdy[s+1]) begin
        if (s == 0) begin
          side_r[s] <= a_side_r;
        end else begin
          side_r[s] <= side_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  // squaring stage
  always_ff @(posedge clk) begin
    if (rdy[MSTG]) begin
      sq0_r    <= SQ_BITS'(q0) * SQ_BITS'(q0);
      sq1_r    <= SQ_BITS'(q1) * SQ_BITS'(q1);
      m_side_r <= side_r[DIV_STAGES-1];
    end
  end

  // round, sum and saturate
  always_comb begin
    m0    = Q_BITS'((sq0_r + RND) >> FRAC_BITS);
    m1    = Q_BITS'((sq1_r + RND) >> FRAC_BITS);
    t0    = '0;
    t1    = '0;
    if (m_side_r.act0) begin
      t0 = m_side_r.neg0 ? -signed'(SUM_BITS'(m0)) : signed'(SUM_BITS'(m0));
    end
    if (m_side_r.act1) begin
      t1 = m_side_r.neg1 ? -signed'(SUM_BITS'(m1)) : signed'(SUM_BITS'(m1));
    end
    sum_v = SUM_BITS'(m_side_r.base) + t0 + t1;
    priority if (sum_v > MAX_V) begin
      sample_nxt = SAMPLE_BITS'(MAX_V);
    end else if (sum_v < MIN_V) begin
      sample_nxt = SAMPLE_BITS'(MIN_V);
    end else begin
      sample_nxt = SAMPLE_BITS'(sum_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OSTG]) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_chan.valid  = v_r[OSTG];
  assign out_chan.sample = sample_r;

`ifndef SYNTHESIS
  a_take_fills_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted request did not reach setup stage");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input stalled while output side is ready");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_chan.ready |-> !in_chan.ready)
    else $error("request accepted into a full stalled pipeline");

  a_zero_inc_no_blep: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && (a_d_r == '0) |-> !a_side_r.act0 && !a_side_r.act1)
    else $error("residual enabled with zero increment");

  a_square_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[MSTG] |-> (!m_side_r.act0 || (sq0_r <= SQ_MAX)) &&
                  (!m_side_r.act1 || (sq1_r <= SQ_MAX)))
    else $error("quotient square out of range");
`endif

endmodule
